@@ sv/ccsc_pkg.sv @@
// Shared types, codes and constants of the command syntax checker.
package ccsc_pkg;

    // Widths of the length and argument count state and of the limit register
    localparam int LENGTH_BITS = 31;
    localparam int COUNT_BITS  = 8;
    localparam int CFG_BITS    = 31;

    // Limit after reset: the largest signed 32-bit value divided by ten
    localparam longint INT_MAX = 64'd2147483647;
    localparam logic [CFG_BITS-1:0] LIMIT_RESET = CFG_BITS'(INT_MAX / 10);

    // Characters of the grammar
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Parse phases
    localparam logic [3:0] PH_NAME      = 4'd0;
    localparam logic [3:0] PH_ARG_FIRST = 4'd1;
    localparam logic [3:0] PH_ARG       = 4'd2;
    localparam logic [3:0] PH_DIGITS    = 4'd3;
    localparam logic [3:0] PH_MINUS     = 4'd4;
    localparam logic [3:0] PH_PAYLOAD   = 4'd5;
    localparam logic [3:0] PH_SEP       = 4'd6;
    localparam logic [3:0] PH_SPACE     = 4'd7;
    localparam logic [3:0] PH_NEWLINE   = 4'd8;
    localparam logic [3:0] PH_DONE      = 4'd9;

    // Verdict codes
    localparam logic [1:0] V_PENDING = 2'd0;
    localparam logic [1:0] V_VALID   = 2'd1;
    localparam logic [1:0] V_INVALID = 2'd2;
    localparam logic [1:0] V_IGNORED = 2'd3;

    // Role codes
    localparam logic [1:0] ROLE_SYNTAX  = 2'd0;
    localparam logic [1:0] ROLE_NAME    = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] role;
        logic [7:0] args_done;
    } t_res;

    // Classified byte handed from front to back
    typedef struct packed {
        logic       first;
        logic       is_digit;
        logic       is_name;
        logic       is_lpar;
        logic       is_rpar;
        logic       is_comma;
        logic       is_space;
        logic       is_minus;
        logic       is_one;
        logic       is_nl;
        logic       is_nul;
        logic [3:0] dval;
    } t_cls;

endpackage

@@ sv/ccsc_front.sv @@
// Front end: accepts command bytes, classifies them and queues them for the parser.
module ccsc_front import ccsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_cls o_cls,
    input  logic i_take
);

    t_cls       w_cls;
    t_cls       r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_wr;
    logic       w_rd;

    // Classify the incoming byte
    always_comb begin
        w_cls          = '0;
        w_cls.first    = i_cmd.first_byte;
        w_cls.is_digit = i_cmd.data_byte inside {[CH_ZERO:CH_NINE]};
        w_cls.is_name  = (i_cmd.data_byte inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_Z],
                                                  [CH_LO_A:CH_LO_Z]}) ||
                         (i_cmd.data_byte == CH_UNDER);
        w_cls.is_lpar  = i_cmd.data_byte == CH_LPAR;
        w_cls.is_rpar  = i_cmd.data_byte == CH_RPAR;
        w_cls.is_comma = i_cmd.data_byte == CH_COMMA;
        w_cls.is_space = i_cmd.data_byte == CH_SPACE;
        w_cls.is_minus = i_cmd.data_byte == CH_MINUS;
        w_cls.is_one   = i_cmd.data_byte == CH_ONE;
        w_cls.is_nl    = i_cmd.data_byte == CH_NL;
        w_cls.is_nul   = i_cmd.data_byte == CH_NUL;
        w_cls.dval     = 4'(i_cmd.data_byte - CH_ZERO);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cls   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // Store the classified beat
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_cls;
        end
    end

endmodule

@@ sv/ccsc_back.sv @@
// Back end: grammar state machine and result queue.
module ccsc_back import ccsc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_cls                i_cls,
    output logic                o_take,
    input  logic [CFG_BITS-1:0] i_limit,
    output logic                o_empty,
    input  logic                i_pop,
    output t_res                o_res
);

    localparam logic [LENGTH_BITS+3:0] LEN_MAX_W = (LENGTH_BITS+4)'({LENGTH_BITS{1'b1}});
    localparam logic [COUNT_BITS-1:0]  CNT_MAX   = {COUNT_BITS{1'b1}};

    // Parse state
    logic [3:0]             r_phase;
    logic                   r_nonempty;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] r_left;
    logic [COUNT_BITS-1:0]  r_total;
    logic [3:0]             n_phase;
    logic                   n_nonempty;
    logic [LENGTH_BITS-1:0] n_len;
    logic [LENGTH_BITS-1:0] n_left;
    logic [COUNT_BITS-1:0]  n_total;

    // State seen by this byte, after a restart
    logic [3:0]             e_phase;
    logic                   e_nonempty;
    logic [LENGTH_BITS-1:0] e_len;
    logic [LENGTH_BITS-1:0] e_left;
    logic [COUNT_BITS-1:0]  e_total;

    logic [LENGTH_BITS+3:0] w_prod;
    logic [LENGTH_BITS-1:0] w_left_dec;
    logic [COUNT_BITS-1:0]  w_total_inc;
    logic                   w_len_full;
    logic [1:0]             w_verdict;
    logic [1:0]             w_role;
    t_res                   w_res;

    // Result queue
    t_res       r_omem [0:1];
    logic       r_owp;
    logic       r_orp;
    logic [1:0] r_ocnt;
    logic [1:0] n_ocnt;
    logic       w_opop;

    assign o_take = i_valid && (r_ocnt != 2'd2);

    // Restart the parse on a first byte
    always_comb begin
        if (i_cls.first) begin
            e_phase    = PH_NAME;
            e_nonempty = 1'b0;
            e_len      = '0;
            e_left     = '0;
            e_total    = '0;
        end else begin
            e_phase    = r_phase;
            e_nonempty = r_nonempty;
            e_len      = r_len;
            e_left     = r_left;
            e_total    = r_total;
        end
    end

    // Length accumulation, payload countdown and argument count
    assign w_prod      = ({4'b0, e_len} << 3) + ({4'b0, e_len} << 1) +
                         (LENGTH_BITS+4)'(i_cls.dval);
    assign w_len_full  = CFG_BITS'(e_len) >= i_limit;
    assign w_left_dec  = (e_left != '0) ? e_left - LENGTH_BITS'(1) : '0;
    assign w_total_inc = (e_total != CNT_MAX) ? e_total + COUNT_BITS'(1) : e_total;

    // Grammar step
    always_comb begin
        n_phase    = e_phase;
        n_nonempty = e_nonempty;
        n_len      = e_len;
        n_left     = e_left;
        n_total    = e_total;
        w_verdict  = V_PENDING;
        w_role     = ROLE_SYNTAX;
        case (e_phase)
            PH_NAME: begin
                if (i_cls.is_name) begin
                    n_nonempty = 1'b1;
                    w_role     = ROLE_NAME;
                end else if (i_cls.is_lpar && e_nonempty) begin
                    n_phase = PH_ARG_FIRST;
                end else begin
                    n_phase   = PH_DONE;
                    w_verdict = V_INVALID;
                end
            end
            PH_ARG_FIRST, PH_ARG: begin
                if (i_cls.is_digit) begin
                    if (i_limit == '0) begin
                        n_phase   = PH_DONE;
                        w_verdict = V_INVALID;
                    end else begin
                        n_len   = LENGTH_BITS'(i_cls.dval);
                        n_phase = PH_DIGITS;
                    end
                end else if (i_cls.is_minus) begin
                    n_phase = PH_MINUS;
                end else if (i_cls.is_rpar && (e_phase == PH_ARG_FIRST)) begin
                    n_phase = PH_NEWLINE;
                end else begin
                    n_phase   = PH_DONE;
                    w_verdict = V_INVALID;
                end
            end
            PH_DIGITS: begin
                if (i_cls.is_digit) begin
                    if (w_len_full) begin
                        n_phase   = PH_DONE;
                        w_verdict = V_INVALID;
                    end else if (w_prod > LEN_MAX_W) begin
                        n_len = LEN_MAX_W[LENGTH_BITS-1:0];
                    end else begin
                        n_len = w_prod[LENGTH_BITS-1:0];
                    end
                end else if (e_len != '0) begin
                    if (i_cls.is_space) begin
                        n_left  = e_len;
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase   = PH_DONE;
                        w_verdict = V_INVALID;
                    end
                end else begin
                    // zero length: count it and check this byte as a separator
                    n_total = w_total_inc;
                    if (i_cls.is_comma) begin
                        n_phase = PH_SPACE;
                    end else if (i_cls.is_rpar) begin
                        n_phase = PH_NEWLINE;
                    end else begin
                        n_phase   = PH_DONE;
                        w_verdict = V_INVALID;
                    end
                end
            end
            PH_MINUS: begin
                if (i_cls.is_one) begin
                    n_total = w_total_inc;
                    n_phase = PH_SEP;
                end else begin
                    n_phase   = PH_DONE;
                    w_verdict = V_INVALID;
                end
            end
            PH_PAYLOAD: begin
                if (i_cls.is_nul) begin
                    n_phase   = PH_DONE;
                    w_verdict = V_INVALID;
                end else begin
                    w_role = ROLE_PAYLOAD;
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_total = w_total_inc;
                        n_phase = PH_SEP;
                    end
                end
            end
            PH_SEP: begin
                if (i_cls.is_comma) begin
                    n_phase = PH_SPACE;
                end else if (i_cls.is_rpar) begin
                    n_phase = PH_NEWLINE;
                end else begin
                    n_phase   = PH_DONE;
                    w_verdict = V_INVALID;
                end
            end
            PH_SPACE: begin
                if (i_cls.is_space) begin
                    n_phase = PH_ARG;
                end else begin
                    n_phase   = PH_DONE;
                    w_verdict = V_INVALID;
                end
            end
            PH_NEWLINE: begin
                n_phase   = PH_DONE;
                w_verdict = i_cls.is_nl ? V_VALID : V_INVALID;
            end
            default: begin
                w_verdict = V_IGNORED;
            end
        endcase
    end

    // Build the result beat, count shown saturated at 255
    always_comb begin
        w_res.verdict   = w_verdict;
        w_res.role      = w_role;
        w_res.args_done = (32'(n_total) > 32'd255) ? 8'hFF : 8'(n_total);
    end

    // Hold or advance the parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NAME;
            r_nonempty <= 1'b0;
            r_len      <= '0;
            r_left     <= '0;
            r_total    <= '0;
        end else if (o_take) begin
            r_phase    <= n_phase;
            r_nonempty <= n_nonempty;
            r_len      <= n_len;
            r_left     <= n_left;
            r_total    <= n_total;
        end
    end

    // Result queue control
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_omem[r_orp];
    assign w_opop  = i_pop && !o_empty;

    always_comb begin
        n_ocnt = r_ocnt;
        if (o_take && !w_opop) begin
            n_ocnt = r_ocnt + 2'd1;
        end else if (!o_take && w_opop) begin
            n_ocnt = r_ocnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            r_ocnt <= n_ocnt;
            if (o_take) begin
                r_owp <= ~r_owp;
            end
            if (w_opop) begin
                r_orp <= ~r_orp;
            end
        end
    end

    // Store the result beat
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_omem[r_owp] <= w_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("result queue overfilled");

    a_verdict_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (w_verdict == V_VALID || w_verdict == V_INVALID)) |=>
        r_phase == PH_DONE)
        else $error("parse did not stop after a verdict");

    a_payload_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && w_role == ROLE_PAYLOAD) |-> (w_verdict == V_PENDING))
        else $error("payload byte carries a final verdict");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_cls.first) |=> (r_total >= $past(r_total)))
        else $error("argument count dropped without a restart");

    a_ignored_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && w_verdict == V_IGNORED) |=> $stable(r_total) && $stable(r_phase))
        else $error("state moved on an ignored byte");
`endif

endmodule

@@ sv/command_line_syntax_checker.sv @@
// Top level of the command syntax checker: limit register, front end and back end.
// Checks NAME(arg, arg, ...) plus newline one byte per beat and returns one result
// beat per byte. One byte is taken every clock cycle while one is queued and the result
// queue has room; a byte passes through the front classify queue, then the parse step
// that writes the result queue. The rate is set by the parse step, whose path is the
// length times ten plus digit add and the limit compare. Both queues are two beats
// deep, so push and pop stall independently. The length limit may be written through
// the config channel only while the block is idle.
module command_line_syntax_checker import ccsc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  t_cmd                i_cmd,
    output logic                empty,
    input  logic                pop,
    output t_res                o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    logic [CFG_BITS-1:0] r_limit;
    logic                w_valid;
    logic                w_take;
    t_cls                w_cls;

    assign o_cfg_ready = 1'b1;

    // Hold the length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    ccsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_cmd   (i_cmd),
        .o_valid (w_valid),
        .o_cls   (w_cls),
        .i_take  (w_take)
    );

    ccsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_cls   (w_cls),
        .o_take  (w_take),
        .i_limit (r_limit),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_res)
    );

endmodule
